// ===== rtl/core/dbcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_pkg
// Types, constants and lead/trail byte rules for the character segmenter.
// ----------------------------------------------------------------------------
package dbcs_pkg;

    localparam int OFFSET_W   = 15;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    localparam logic [7:0] ESCAPE_BYTE = 8'h7c;

    typedef enum logic [2:0] {
        ENC_NONE  = 3'd0,
        ENC_SJIS  = 3'd1,
        ENC_BIG5  = 3'd2,
        ENC_GBK   = 3'd3,
        ENC_JOHAB = 3'd4,
        ENC_THAI  = 3'd5
    } encoding_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [15:0]         char_code;
        logic                is_double;
        logic [OFFSET_W-1:0] char_offset;
        logic                last_of_step;
    } out_item_t;

    function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic escape_letter(input logic [7:0] b);
        return (b == "i") || (b == "b") || (b == "u") || (b == "k") || (b == "p") ||
               (b == "r") || (b == "l") || (b == "c") || (b == "t") || (b == "n");
    endfunction

    function automatic logic forms_pair(input logic [7:0] lead, input logic [7:0] trail,
                                        input encoding_t enc);
        logic ok;
        ok = 1'b0;
        case (enc)
            ENC_SJIS:
                ok = (in_rng(lead, 8'h81, 8'h9f) || in_rng(lead, 8'he0, 8'hfe)) &&
                     in_rng(trail, 8'h40, 8'hfc) && (trail != 8'h7f);
            ENC_BIG5:
                ok = in_rng(lead, 8'ha1, 8'hfe) && in_rng(trail, 8'ha1, 8'hfe);
            ENC_GBK:
                ok = in_rng(lead, 8'h81, 8'hfe) &&
                     (in_rng(trail, 8'h40, 8'h7e) || in_rng(trail, 8'ha1, 8'hfe));
            ENC_JOHAB:
                ok = in_rng(lead, 8'h81, 8'hfe) &&
                     (in_rng(trail, 8'h41, 8'h5a) || in_rng(trail, 8'h61, 8'h7a) ||
                      in_rng(trail, 8'h81, 8'hfe));
            ENC_THAI:
                ok = (in_rng(lead, 8'h84, 8'hd3) || in_rng(lead, 8'hd8, 8'hde) ||
                      in_rng(lead, 8'he0, 8'hf9)) &&
                     (in_rng(trail, 8'h41, 8'h7e) || in_rng(trail, 8'h81, 8'hfe));
            default:
                ok = 1'b0;
        endcase
        if ((lead == ESCAPE_BYTE) && escape_letter(trail))
        begin
            ok = 1'b1;
        end
        if (lead == 8'h00)
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // saturating offset advance
    function automatic logic [OFFSET_W-1:0] adv_offset(input logic [OFFSET_W-1:0] off,
                                                       input logic [1:0] n);
        logic [OFFSET_W:0] sum;
        sum = {1'b0, off} + {{(OFFSET_W-1){1'b0}}, n};
        return (sum > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : sum[OFFSET_W-1:0];
    endfunction

endpackage

// ===== rtl/core/dbcs_character_segmenter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcs_character_segmenter_core
// Splits a byte stream into single- and double-byte characters.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  in_item_t  (byte, end of string)
// out       source     out_valid/out_stall out_item_t (code, double, offset, last)
// cfg       sink       cfg_we             cfg_data   (encoding, above 5 gives none)
//
// One byte per cycle is accepted while in_stall is low; results enter a
// 4-entry output queue the same cycle and leave one per cycle while out_stall
// is low. in_stall rises while fewer than two queue slots are free, so a byte
// that yields two results (end of string with an unpaired held byte) fits.
// Reset clears the held byte, the offset, the queue and the encoding (none).
// ----------------------------------------------------------------------------
module dbcs_character_segmenter_core
    import dbcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    encoding_t           enc_reg;
    logic [7:0]          pend_byte_reg,  pend_byte_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [OFFSET_W-1:0] pend_off_reg,   pend_off_next;

    out_item_t           fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]    count_reg,  count_next;

    logic                accept;
    logic                pop;
    logic                pair;
    logic [OFFSET_W-1:0] off_after;
    out_item_t           res0, res1;
    logic [1:0]          n_res;

    assign accept    = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign in_stall  = (count_reg > (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign out_data  = fifo_reg[rd_ptr_reg];

    assign pair = pend_valid_reg && forms_pair(pend_byte_reg, in_data.byte_value, enc_reg);

    always_comb
    begin
        res0            = '0;
        res1            = '0;
        n_res           = 2'd0;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        pend_off_next   = pend_off_reg;
        off_after       = pend_off_reg;

        if (pair)
        begin
            res0.char_code    = {pend_byte_reg, in_data.byte_value};
            res0.is_double    = 1'b1;
            res0.char_offset  = pend_off_reg;
            res0.last_of_step = 1'b1;
            n_res             = 2'd1;
            pend_valid_next   = 1'b0;
            pend_off_next     = in_data.end_of_string ? '0 : adv_offset(pend_off_reg, 2'd2);
        end
        else
        begin
            if (pend_valid_reg)
            begin
                res0.char_code    = {8'h00, pend_byte_reg};
                res0.is_double    = 1'b0;
                res0.char_offset  = pend_off_reg;
                res0.last_of_step = !in_data.end_of_string;
                n_res             = 2'd1;
                off_after         = adv_offset(pend_off_reg, 2'd1);
            end
            if (in_data.end_of_string)
            begin
                res1.char_code    = {8'h00, in_data.byte_value};
                res1.is_double    = 1'b0;
                res1.char_offset  = off_after;
                res1.last_of_step = 1'b1;
                // single result goes in the first slot when nothing was held
                if (!pend_valid_reg)
                begin
                    res0 = res1;
                end
                n_res           = n_res + 2'd1;
                pend_valid_next = 1'b0;
                pend_byte_next  = 8'h00;
                pend_off_next   = '0;
            end
            else
            begin
                pend_byte_next  = in_data.byte_value;
                pend_valid_next = 1'b1;
                pend_off_next   = off_after;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + FIFO_AW'(n_res);
            count_next  = count_next + (FIFO_AW+1)'(n_res);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg        <= ENC_NONE;
            pend_byte_reg  <= 8'h00;
            pend_valid_reg <= 1'b0;
            pend_off_reg   <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enc_reg <= (cfg_data > ENC_THAI) ? ENC_NONE : encoding_t'(cfg_data);
            end
            if (accept)
            begin
                pend_byte_reg  <= pend_byte_next;
                pend_valid_reg <= pend_valid_next;
                pend_off_reg   <= pend_off_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && (n_res != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (accept && (n_res == 2'd2))
        begin
            fifo_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

endmodule
